[rtl/stof_pkg.sv]
package stof_pkg;

    // Dimensions that take part in the index split (innermost first)
    localparam int MAX_DIMS = 4;
    localparam int NUM_DIMS = 4;

    localparam int IDX_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int STRIDE_W = 32;
    localparam int OFFSET_W = 50;
    localparam int PROD_W   = SIZE_W + STRIDE_W;
    localparam int PAIR_W   = PROD_W + 1;

    // Divider: restoring, BITS_PER_STAGE quotient bits per pipeline stage
    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES_PER_DIV = IDX_W / BITS_PER_STAGE;
    localparam int NUM_DIVS       = NUM_DIMS - 1;
    localparam int DIV_STAGES     = NUM_DIVS * STAGES_PER_DIV;
    localparam int DIM_W          = 2;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SIZE_INNER    = 3'd0;
    localparam logic [2:0] REG_SIZE_SECOND   = 3'd1;
    localparam logic [2:0] REG_SIZE_THIRD    = 3'd2;
    localparam logic [2:0] REG_SIZE_OUTER    = 3'd3;
    localparam logic [2:0] REG_STRIDE_INNER  = 3'd4;
    localparam logic [2:0] REG_STRIDE_SECOND = 3'd5;
    localparam logic [2:0] REG_STRIDE_THIRD  = 3'd6;
    localparam logic [2:0] REG_STRIDE_OUTER  = 3'd7;

    // Item travelling down the divider chain. work holds the dividend bits not yet
    // consumed at the top and the quotient bits produced so far at the bottom.
    typedef struct packed {
        logic [NUM_DIVS-1:0][SIZE_W-1:0] coord;
        logic [SIZE_W-1:0]               rem;
        logic [IDX_W-1:0]                work;
    } pipe_t;

    typedef struct packed {
        logic [SIZE_W-1:0] divisor;
        logic              finish;
        logic [DIM_W-1:0]  dim;
    } div_ctl_t;

    // Dimensions beyond MAX_DIMS behave as size 1
    function automatic logic [SIZE_W-1:0] eff_size(input int unsigned d,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] res;
        res = (d < MAX_DIMS) ? size : SIZE_W'(1);
        return res;
    endfunction

endpackage

[rtl/strided_tensor_offset.sv]
// Strided tensor address generator. Each linear_index transaction is split into
// per-dimension coordinates by division by the configured sizes, innermost first,
// and source_offset is the sum of coordinate times stride; an index at or beyond
// the product of the sizes gives out_of_range = 1 and offset 0. One index is taken
// every cycle while the output is not stalled; each result passes through 24
// divider stages (three 32-bit by 16-bit restoring divisions, 4 quotient bits per
// stage) followed by a multiply stage and two adder stages. Registers sit at byte
// addresses 0x00-0x0C (sizes, innermost first) and 0x10-0x1C (strides); they
// should be written only while no transaction is in flight.
module strided_tensor_offset (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stof_pkg::ADDR_W-1:0]        paddr,
    input  logic [stof_pkg::DATA_W-1:0]        pwdata,
    output logic [stof_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [stof_pkg::IDX_W-1:0]         linear_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [stof_pkg::OFFSET_W-1:0]      source_offset,
    output logic                               out_of_range
);
    import stof_pkg::*;

    logic [SIZE_W-1:0]   size_reg   [NUM_DIMS];
    logic [STRIDE_W-1:0] stride_reg [NUM_DIMS];
    logic [SIZE_W-1:0]   size_eff   [NUM_DIMS];
    logic                size_zero;
    logic [2:0]          reg_idx;
    logic                cfg_write;

    pipe_t pipe_data  [DIV_STAGES+1];
    logic  pipe_valid [DIV_STAGES+1];
    logic  pipe_ready [DIV_STAGES+1];

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                size_reg[d]   <= SIZE_W'(1);
                stride_reg[d] <= (d == 0) ? STRIDE_W'(1) : '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_SIZE_INNER:    size_reg[0]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_SECOND:   size_reg[1]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_THIRD:    size_reg[2]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_OUTER:    size_reg[3]   <= pwdata[SIZE_W-1:0];
                REG_STRIDE_INNER:  stride_reg[0] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_SECOND: stride_reg[1] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_THIRD:  stride_reg[2] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_OUTER:  stride_reg[3] <= pwdata[STRIDE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SIZE_INNER:    prdata = DATA_W'(size_reg[0]);
            REG_SIZE_SECOND:   prdata = DATA_W'(size_reg[1]);
            REG_SIZE_THIRD:    prdata = DATA_W'(size_reg[2]);
            REG_SIZE_OUTER:    prdata = DATA_W'(size_reg[3]);
            REG_STRIDE_INNER:  prdata = DATA_W'(stride_reg[0]);
            REG_STRIDE_SECOND: prdata = DATA_W'(stride_reg[1]);
            REG_STRIDE_THIRD:  prdata = DATA_W'(stride_reg[2]);
            REG_STRIDE_OUTER:  prdata = DATA_W'(stride_reg[3]);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        size_zero = 1'b0;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            size_eff[d] = eff_size(d, size_reg[d]);
            if (size_eff[d] == '0)
            begin
                size_zero = 1'b1;
            end
        end
    end

    // ---------------- divider chain ----------------
    assign pipe_valid[0]      = in_valid;
    assign in_ready           = pipe_ready[0];
    assign pipe_data[0].work  = linear_index;
    assign pipe_data[0].rem   = '0;
    assign pipe_data[0].coord = '0;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        div_ctl_t ctl;
        assign ctl.divisor = size_eff[s / STAGES_PER_DIV];
        assign ctl.finish  = ((s % STAGES_PER_DIV) == (STAGES_PER_DIV - 1));
        assign ctl.dim     = DIM_W'(s / STAGES_PER_DIV);

        stof_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (pipe_valid[s]),
            .up_ready (pipe_ready[s]),
            .up_data  (pipe_data[s]),
            .ctl      (ctl),
            .dn_valid (pipe_valid[s+1]),
            .dn_ready (pipe_ready[s+1]),
            .dn_data  (pipe_data[s+1])
        );
    end

    // ---------------- multiply and sum ----------------
    stof_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (pipe_valid[DIV_STAGES]),
        .up_ready      (pipe_ready[DIV_STAGES]),
        .up_data       (pipe_data[DIV_STAGES]),
        .outer_size    (size_eff[NUM_DIMS-1]),
        .size_zero     (size_zero),
        .stride        (stride_reg),
        .dn_valid      (out_valid),
        .dn_ready      (out_ready),
        .source_offset (source_offset),
        .out_of_range  (out_of_range)
    );

endmodule

[rtl/stof_div_stage.sv]
module stof_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  stof_pkg::pipe_t     up_data,
    input  stof_pkg::div_ctl_t  ctl,
    output logic                dn_valid,
    input  logic                dn_ready,
    output stof_pkg::pipe_t     dn_data
);
    import stof_pkg::*;

    pipe_t data_reg;
    pipe_t data_next;
    logic  valid_reg;

    always_comb
    begin
        logic [IDX_W-1:0]  work;
        logic [SIZE_W-1:0] rem;
        logic [SIZE_W:0]   trial;
        logic [SIZE_W:0]   divisor_ext;
        data_next   = up_data;
        work        = up_data.work;
        rem         = up_data.rem;
        divisor_ext = {1'b0, ctl.divisor};
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial = {rem, work[IDX_W-1]};
            work  = {work[IDX_W-2:0], 1'b0};
            if (trial >= divisor_ext)
            begin
                rem     = SIZE_W'(trial - divisor_ext);
                work[0] = 1'b1;
            end
            else
            begin
                rem = trial[SIZE_W-1:0];
            end
        end
        data_next.work = work;
        // last stage of a division: remainder is this dimension's coordinate
        if (ctl.finish)
        begin
            data_next.coord[ctl.dim] = rem;
            data_next.rem            = '0;
        end
        else
        begin
            data_next.rem = rem;
        end
    end

    assign up_ready = ~valid_reg | dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[rtl/stof_mac.sv]
module stof_mac (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       up_valid,
    output logic                                       up_ready,
    input  stof_pkg::pipe_t                            up_data,
    input  logic [stof_pkg::SIZE_W-1:0]                outer_size,
    input  logic                                       size_zero,
    input  logic [stof_pkg::STRIDE_W-1:0]              stride [stof_pkg::NUM_DIMS],
    output logic                                       dn_valid,
    input  logic                                       dn_ready,
    output logic [stof_pkg::OFFSET_W-1:0]              source_offset,
    output logic                                       out_of_range
);
    import stof_pkg::*;

    logic [SIZE_W-1:0]   coord_full [NUM_DIMS];
    logic [PROD_W-1:0]   prod_next  [NUM_DIMS];
    logic [PROD_W-1:0]   prod_reg   [NUM_DIMS];
    logic                flag_next;
    logic                flag_a_reg;
    logic                valid_a_reg;
    logic                ready_a;

    logic [PAIR_W-1:0]   pair_reg [2];
    logic                flag_b_reg;
    logic                valid_b_reg;
    logic                ready_b;

    logic [OFFSET_W-1:0] offset_reg;
    logic                flag_c_reg;
    logic                valid_c_reg;
    logic                ready_c;

    // Outermost coordinate is the final quotient; only valid when in range
    always_comb
    begin
        for (int d = 0; d < NUM_DIVS; d++)
        begin
            coord_full[d] = up_data.coord[d];
        end
        coord_full[NUM_DIMS-1] = up_data.work[SIZE_W-1:0];
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            prod_next[d] = PROD_W'(coord_full[d]) * PROD_W'(stride[d]);
        end
        // index >= product of sizes exactly when the last quotient reaches the outer size
        flag_next = (up_data.work >= IDX_W'(outer_size)) || size_zero;
    end

    assign ready_c  = ~valid_c_reg | dn_ready;
    assign ready_b  = ~valid_b_reg | ready_c;
    assign ready_a  = ~valid_a_reg | ready_b;
    assign up_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && ready_a)
        begin
            prod_reg   <= prod_next;
            flag_a_reg <= flag_next;
        end
        if (valid_a_reg && ready_b)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
            flag_b_reg  <= flag_a_reg;
        end
        if (valid_b_reg && ready_c)
        begin
            offset_reg <= flag_b_reg ? '0
                                     : OFFSET_W'(pair_reg[0]) + OFFSET_W'(pair_reg[1]);
            flag_c_reg <= flag_b_reg;
        end
    end

    assign dn_valid      = valid_c_reg;
    assign source_offset = offset_reg;
    assign out_of_range  = flag_c_reg;

endmodule

[tb/strided_tensor_offset_test.sv]
module strided_tensor_offset_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stof_pkg::*;

    localparam int unsigned IDLE_PCT    = 18;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Tracks the register file and the offsets still owed by the block
    class offset_scoreboard;
        typedef struct {
            logic [OFFSET_W-1:0] offset;
            logic                oor;
        } offset_result_t;

        logic [SIZE_W-1:0]   dim_size[NUM_DIMS];
        logic [STRIDE_W-1:0] dim_stride[NUM_DIMS];
        offset_result_t      owed_q[$];
        int unsigned         errors;

        function new();
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                dim_size[d]   = 1;
                dim_stride[d] = 0;
            end
            dim_stride[0] = 1;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] reg_idx, logic [DATA_W-1:0] value);
            if (reg_idx < REG_STRIDE_INNER)
                dim_size[reg_idx] = value[SIZE_W-1:0];
            else
                dim_stride[reg_idx - REG_STRIDE_INNER] = value[STRIDE_W-1:0];
        endfunction

        // Product of the used sizes; 65535^4 still fits in 64 bits
        function longint unsigned index_limit();
            longint unsigned total;
            total = 1;
            for (int d = 0; d < MAX_DIMS; d++)
                total = total * 64'(dim_size[d]);
            return total;
        endfunction

        function void note_index(logic [IDX_W-1:0] idx);
            offset_result_t  want;
            longint unsigned rem;
            longint unsigned sz;
            longint unsigned sum;
            sum = 0;
            if (64'(idx) >= index_limit())
            begin
                want.offset = '0;
                want.oor    = 1'b1;
            end
            else
            begin
                rem = 64'(idx);
                for (int d = 0; d < MAX_DIMS; d++)
                begin
                    sz  = 64'(dim_size[d]);
                    sum = sum + (rem % sz) * 64'(dim_stride[d]);
                    rem = rem / sz;
                end
                want.offset = sum[OFFSET_W-1:0];
                want.oor    = 1'b0;
            end
            owed_q.push_back(want);
        endfunction

        function void check_result(logic [OFFSET_W-1:0] offset, logic oor);
            offset_result_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with none owed: offset %0h out_of_range %0b",
                             $time, offset, oor);
                return;
            end
            want = owed_q.pop_front();
            if (offset !== want.offset)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: source_offset expected %0h actual %0h",
                             $time, want.offset, offset);
            end
            if (oor !== want.oor)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, want.oor, oor);
            end
        endfunction

        function int unsigned owed();
            return owed_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [IDX_W-1:0]    linear_index = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [OFFSET_W-1:0] source_offset;
    logic                out_of_range;

    offset_scoreboard sb = new();

    bit          calm = 1'b0;
    bit          stall_armed = 1'b0;
    bit          stall_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    strided_tensor_offset dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .linear_index  (linear_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .source_offset (source_offset),
        .out_of_range  (out_of_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run timed out", $time);
            $display("** strided_tensor_offset: FAILED **");
            $finish;
        end
    end

    // Result side: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(source_offset, out_of_range);
        if (stall_armed && !stall_done)
        begin
            stall_done <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic write_reg(input logic [2:0] reg_idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // junk puts random bits above the 16-bit size fields
    task automatic configure(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                             input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
                             input logic [STRIDE_W-1:0] t0, input logic [STRIDE_W-1:0] t1,
                             input logic [STRIDE_W-1:0] t2, input logic [STRIDE_W-1:0] t3,
                             input bit junk);
        logic [15:0] hi;
        hi = junk ? 16'($urandom) : 16'h0;
        write_reg(REG_SIZE_INNER,    {hi, s0});
        write_reg(REG_SIZE_SECOND,   {hi, s1});
        write_reg(REG_SIZE_THIRD,    {hi, s2});
        write_reg(REG_SIZE_OUTER,    {hi, s3});
        write_reg(REG_STRIDE_INNER,  t0);
        write_reg(REG_STRIDE_SECOND, t1);
        write_reg(REG_STRIDE_THIRD,  t2);
        write_reg(REG_STRIDE_OUTER,  t3);
    endtask

    task automatic send_index(input logic [IDX_W-1:0] idx);
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid     <= 1'b1;
        linear_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_index(idx);
    endtask

    // Mostly in-range indices, some right at the limit, some anywhere
    function automatic logic [IDX_W-1:0] pick_index(input longint unsigned total);
        int unsigned sel;
        sel = $urandom_range(9);
        if (total == 0 || sel >= 8 || total > 64'hFFFF_FFFF)
            return $urandom;
        if (sel == 7)
            return ($urandom_range(1) != 0) ? IDX_W'(total - 1) : IDX_W'(total);
        return IDX_W'(64'($urandom) % total);
    endfunction

    task automatic send_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_index(pick_index(sb.index_limit()));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 6)
            return SIZE_W'($urandom_range(8, 1));
        if (k < 8)
            return SIZE_W'(1);
        if (k == 8)
            return SIZE_W'($urandom_range(300, 16));
        return ($urandom_range(1) != 0) ? SIZE_W'(16'hFFFF) : SIZE_W'($urandom);
    endfunction

    function automatic logic [STRIDE_W-1:0] pick_stride();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 5)
            return STRIDE_W'($urandom_range(64));
        if (k < 8)
            return $urandom;
        if (k == 8)
            return '0;
        return '1;
    endfunction

    initial
    begin
        logic [IDX_W-1:0] picks[$];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: only index 0 is in range
        picks = '{32'h0, 32'h1, 32'hFFFF_FFFF};
        foreach (picks[i])
            send_index(picks[i]);
        send_random(3);
        drain();

        // 2x5x4x3 tensor with distinct strides; covers carries and the limit
        configure(16'd3, 16'd4, 16'd5, 16'd2, 32'd1, 32'd7, 32'd100, 32'd1000, 1'b0);
        picks = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd11, 32'd12, 32'd19, 32'd20, 32'd59,
                  32'd60, 32'd119, 32'd120, 32'h8000_0000, 32'hFFFF_FFFF};
        foreach (picks[i])
            send_index(picks[i]);
        send_random(40);
        stall_armed <= 1'b1;
        send_random(196);
        drain();

        // Largest sizes and strides, no idling on either side
        calm <= 1'b1;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        picks = '{32'h0, 32'hFFFF_FFFF, 32'd65534, 32'd65535, 32'hAAAA_5555};
        foreach (picks[i])
            send_index(picks[i]);
        send_random(195);
        drain();
        calm <= 1'b0;

        // A zero size makes every index out of range
        configure(16'd4, 16'd3, 16'd0, 16'd2, 32'd1, 32'd4, 32'd16, 32'd64, 1'b1);
        picks = '{32'h0, 32'hFFFF_FFFF};
        foreach (picks[i])
            send_index(picks[i]);
        send_random(48);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            configure(pick_size(), pick_size(), pick_size(), pick_size(),
                      pick_stride(), pick_stride(), pick_stride(), pick_stride(),
                      ($urandom_range(1) != 0));
            send_random(140);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("** strided_tensor_offset: PASSED **");
        else
            $display("** strided_tensor_offset: FAILED **");
        $finish;
    end

endmodule

[strided_tensor_offset.f]
rtl/stof_pkg.sv
rtl/stof_div_stage.sv
rtl/stof_mac.sv
rtl/strided_tensor_offset.sv
tb/strided_tensor_offset_test.sv
